### design/sobol_sequence_generator_macros.svh
// Assertion helpers used by the Sobol sequence generator.
// Each macro expects clk and rst_n in scope.
`ifndef SOBOL_SEQUENCE_GENERATOR_MACROS_SVH
`define SOBOL_SEQUENCE_GENERATOR_MACROS_SVH

// Same-cycle implication
`define SOB_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication
`define SOB_ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

### design/sobol_pkg.sv
package sobol_pkg;

  // Fixed field widths of the result and config port, and the seed table stride
  localparam int COORD_W     = 30;
  localparam int DIM_IDX_W   = 3;
  localparam int CFG_W       = 3;
  localparam int SEED_STRIDE = 6;

  // Primitive polynomial degree and inner coefficients, entry 0 unused
  localparam logic [2:0] POLY_DEGREE [7] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4};
  localparam logic [2:0] POLY_COEFFS [7] = '{3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd4};

  // Initial direction seeds, row stride SEED_STRIDE per bit position
  localparam logic [3:0] SEED_VALUES [25] = '{
    4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd3, 4'd1, 4'd1,
    4'd5, 4'd7, 4'd7, 4'd3, 4'd3, 4'd5, 4'd15, 4'd11, 4'd5, 4'd15, 4'd13, 4'd9
  };

  // Top-level sequencer: table build after reset, then normal operation
  typedef enum logic {
    SOB_BUILD,
    SOB_RUN
  } sob_state_t;

endpackage

### design/sobol_ram.sv
// Simple dual-port RAM, one write and one registered read port
module sobol_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/sobol_sequence_generator.sv
// Channel | Direction | Handshake            | Payload
// cfg     | in        | cfg_wr_en            | cfg_wr_data (dimensions)
// in      | in        | in_valid / in_stall  | in_request
// out     | out       | out_valid / out_stall| out_dimension_index, out_coordinate,
//         |           |                      | out_last, out_exhausted
//
// After reset the direction table is built one entry per cycle; in_stall stays high
// until it is done. A point with n dimensions issues one coordinate per cycle unless
// the output stalls, through the coordinate memory read-modify-write; the next request
// is taken in the cycle the last coordinate of the previous one issues. Each accepted
// point passes the issue, modify and output registers in turn. out_stall freezes the
// pipeline while out_valid is high; one pending request is still taken while stalled.
module sobol_sequence_generator
  import sobol_pkg::*;
#(
  parameter int MAX_BITS = 30,
  parameter int MAX_DIMS = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_request,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DIM_IDX_W-1:0] out_dimension_index,
  output logic [COORD_W-1:0]   out_coordinate,
  output logic                 out_last,
  output logic                 out_exhausted
);

  `include "sobol_sequence_generator_macros.svh"

  localparam int PW        = $clog2(MAX_BITS);
  localparam int DIM_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DIR_AW    = DIM_W + PW;
  localparam int DIR_DEPTH = 1 << DIR_AW;
  localparam int CRD_DEPTH = 1 << DIM_W;

  sob_state_t state_r, state_nxt;

  // table builder
  logic [DIM_W-1:0]    bd_r;
  logic [PW-1:0]       bb_r;
  logic [MAX_BITS-1:0] win_r [4];
  logic [MAX_BITS-1:0] bld_val;
  logic                bld_done;

  // config and counter
  logic [CFG_W-1:0]    dims_r;
  logic [DIM_W-1:0]    lastk;
  logic [MAX_BITS-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0]       pos_c;
  logic                cnt_full;

  // issue stage
  logic             iss_busy_r, iss_busy_nxt;
  logic [DIM_W-1:0] iss_k_r, iss_k_nxt;
  logic [DIM_W-1:0] iss_last_r, iss_last_nxt;
  logic [PW-1:0]    iss_pos_r, iss_pos_nxt;
  logic             iss_exh_r, iss_exh_nxt;
  logic             iss_done;
  logic             adv;
  logic             in_acc;
  logic             start;
  logic             rd_en;

  // modify stage
  logic                b_vld_r;
  logic [DIM_W-1:0]    b_k_r;
  logic                b_last_r;
  logic                b_exh_r;
  logic                b_fwd_r;
  logic [MAX_BITS-1:0] b_fwd_data_r;
  logic                b_cvld_r;
  logic [MAX_BITS-1:0] b_old;
  logic [MAX_BITS-1:0] b_new;
  logic [COORD_W+MAX_BITS-1:0] b_ext;

  // memories
  logic [MAX_BITS-1:0]  dir_q;
  logic [MAX_BITS-1:0]  crd_q;
  logic                 crd_we;
  logic [CRD_DEPTH-1:0] crd_vld_r;

  // output register
  logic                 out_valid_r;
  logic [DIM_IDX_W-1:0] out_dim_r;
  logic [COORD_W-1:0]   out_crd_r;
  logic                 out_last_r;
  logic                 out_exh_r;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SOB_BUILD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SOB_BUILD: begin
        if (bld_done) begin
          state_nxt = SOB_RUN;
        end
      end
      SOB_RUN: begin
        state_nxt = SOB_RUN;
      end
      default: begin
        state_nxt = SOB_BUILD;
      end
    endcase
  end

  // ---------------------------------------------------------------- table build
  assign bld_done = (bd_r == DIM_W'(MAX_DIMS - 1)) && (bb_r == PW'(MAX_BITS - 1));

  // one direction number per cycle from seeds or the recurrence window
  always_comb begin
    logic [2:0]          pidx;
    logic [2:0]          deg;
    logic [2:0]          coef;
    logic [4:0]          sidx;
    logic [PW-1:0]       shamt;
    logic [MAX_BITS+3:0] seed_ext;
    logic [MAX_BITS-1:0] rec;
    pidx     = 3'(bd_r) + 3'd1;
    deg      = POLY_DEGREE[pidx];
    coef     = POLY_COEFFS[pidx];
    sidx     = 5'(bb_r[1:0]) * 5'(SEED_STRIDE) + 5'(bd_r) + 5'd1;
    shamt    = PW'(MAX_BITS - 1) - bb_r;
    seed_ext = {{MAX_BITS{1'b0}}, SEED_VALUES[sidx]} << shamt;
    rec      = win_r[2'(deg - 3'd1)];
    rec      = rec ^ (rec >> deg);
    for (int l = 1; l < 4; l++) begin
      if ((3'(l) < deg) && coef[2'(deg - 3'(l) - 3'd1)]) begin
        rec = rec ^ win_r[l-1];
      end
    end
    if (bb_r < PW'(deg)) begin
      bld_val = seed_ext[MAX_BITS-1:0];
    end else begin
      bld_val = rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bd_r <= '0;
      bb_r <= '0;
    end else if (state_r == SOB_BUILD) begin
      if (bb_r == PW'(MAX_BITS - 1)) begin
        bb_r <= '0;
        bd_r <= bd_r + 1'b1;
      end else begin
        bb_r <= bb_r + 1'b1;
      end
    end
  end

  // recent entries of the current dimension, newest first
  always_ff @(posedge clk) begin
    if (state_r == SOB_BUILD) begin
      win_r[0] <= bld_val;
      for (int i = 1; i < 4; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      dims_r <= cfg_wr_data;
    end
  end

  // last active dimension index, with the dimension count clamped to 1..MAX_DIMS
  always_comb begin
    if (dims_r == '0) begin
      lastk = '0;
    end else if (dims_r > CFG_W'(MAX_DIMS)) begin
      lastk = DIM_W'(MAX_DIMS - 1);
    end else begin
      lastk = DIM_W'(dims_r - CFG_W'(1));
    end
  end

  // lowest zero bit of the point counter
  always_comb begin
    pos_c = '0;
    for (int b = MAX_BITS - 1; b >= 0; b--) begin
      if (!cnt_r[b]) begin
        pos_c = PW'(b);
      end
    end
  end

  assign cnt_full = &cnt_r;

  // ---------------------------------------------------------------- issue stage
  assign adv      = !out_valid_r || !out_stall;
  assign iss_done = iss_busy_r && adv && (iss_k_r == iss_last_r);
  assign in_stall = (state_r != SOB_RUN) || (iss_busy_r && !iss_done);
  assign in_acc   = in_valid && !in_stall;
  assign start    = in_acc && in_request;
  assign rd_en    = iss_busy_r && adv;

  always_comb begin
    iss_busy_nxt = iss_busy_r;
    iss_k_nxt    = iss_k_r;
    iss_last_nxt = iss_last_r;
    iss_pos_nxt  = iss_pos_r;
    iss_exh_nxt  = iss_exh_r;
    cnt_nxt      = cnt_r;
    if (start) begin
      iss_busy_nxt = 1'b1;
      iss_k_nxt    = '0;
      iss_last_nxt = lastk;
      iss_pos_nxt  = pos_c;
      iss_exh_nxt  = cnt_full;
      if (!cnt_full) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end else if (iss_done) begin
      iss_busy_nxt = 1'b0;
    end else if (rd_en) begin
      iss_k_nxt = iss_k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_busy_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      iss_busy_r <= iss_busy_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_k_r    <= iss_k_nxt;
    iss_last_r <= iss_last_nxt;
    iss_pos_r  <= iss_pos_nxt;
    iss_exh_r  <= iss_exh_nxt;
  end

  // ---------------------------------------------------------------- memories
  sobol_ram #(
    .WIDTH (MAX_BITS),
    .DEPTH (DIR_DEPTH)
  ) u_dir_ram (
    .clk     (clk),
    .wr_en   (state_r == SOB_BUILD),
    .wr_addr ({bd_r, bb_r}),
    .wr_data (bld_val),
    .rd_en   (rd_en),
    .rd_addr ({iss_k_r, iss_pos_r}),
    .rd_data (dir_q)
  );

  sobol_ram #(
    .WIDTH (MAX_BITS),
    .DEPTH (CRD_DEPTH)
  ) u_crd_ram (
    .clk     (clk),
    .wr_en   (crd_we),
    .wr_addr (b_k_r),
    .wr_data (b_new),
    .rd_en   (rd_en),
    .rd_addr (iss_k_r),
    .rd_data (crd_q)
  );

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crd_vld_r <= '0;
    end else if (crd_we) begin
      crd_vld_r[b_k_r] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- modify stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= iss_busy_r;
    end
  end

  // capture a write-back to the entry being read in the same cycle
  always_ff @(posedge clk) begin
    if (adv) begin
      b_k_r        <= iss_k_r;
      b_last_r     <= (iss_k_r == iss_last_r);
      b_exh_r      <= iss_exh_r;
      b_fwd_r      <= crd_we && (b_k_r == iss_k_r);
      b_fwd_data_r <= b_new;
      b_cvld_r     <= crd_vld_r[iss_k_r];
    end
  end

  always_comb begin
    if (b_fwd_r) begin
      b_old = b_fwd_data_r;
    end else if (b_cvld_r) begin
      b_old = crd_q;
    end else begin
      b_old = '0;
    end
    b_new = b_exh_r ? b_old : (b_old ^ dir_q);
    b_ext = {{COORD_W{1'b0}}, b_new};
  end

  assign crd_we = b_vld_r && adv && !b_exh_r;

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_vld_r) begin
      out_dim_r  <= DIM_IDX_W'(b_k_r);
      out_crd_r  <= b_ext[COORD_W-1:0];
      out_last_r <= b_last_r;
      out_exh_r  <= b_exh_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_dimension_index = out_dim_r;
  assign out_coordinate      = out_crd_r;
  assign out_last            = out_last_r;
  assign out_exhausted       = out_exh_r;

  // ---------------------------------------------------------------- checks
  `SOB_ASSERT_NXT(a_point_contiguous, out_valid && !out_stall && !out_last,
    out_valid && (out_dimension_index == $past(out_dimension_index) + 3'd1),
    "coordinates of one point not delivered back to back")
  `SOB_ASSERT_NXT(a_cnt_only_on_request, !(in_valid && !in_stall && in_request),
    $stable(cnt_r), "point counter moved without a request")
  `SOB_ASSERT_IMP(a_quiet_during_build, state_r == SOB_BUILD,
    !out_valid_r && !iss_busy_r && !b_vld_r, "pipeline active during table build")
  `SOB_ASSERT_NXT(a_exhaust_flagged, start && cnt_full,
    iss_exh_r && $stable(cnt_r), "exhausted request not flagged")

endmodule

### verif/sobol_sequence_generator_tb.sv
module sobol_sequence_generator_tb
  import sobol_pkg::*;
();

  localparam int MAX_BITS = 30;
  localparam int MAX_DIMS = 6;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT = 400000;

  // One coordinate as it leaves the block
  typedef struct packed {
    logic [DIM_IDX_W-1:0] dim_idx;
    logic [COORD_W-1:0]   coord;
    logic                 last;
    logic                 exhausted;
  } coord_result_t;

  // Tracks the point sequence and holds the coordinates still owed by the block
  class sobol_point_checker;
    logic [COORD_W-1:0] dir_num [MAX_DIMS][MAX_BITS];
    logic [COORD_W-1:0] coords [MAX_DIMS];
    logic [COORD_W-1:0] point_count;
    logic [CFG_W-1:0]   dims_reg;
    coord_result_t      expected_coords [$];
    int                 errors;

    function new();
      int deg;
      int unsigned val;
      int unsigned poly;
      errors = 0;
      dims_reg = 1;
      point_count = '0;
      foreach (coords[k]) coords[k] = '0;
      // Direction numbers: seeds in the top bits, then the polynomial recurrence
      for (int d = 0; d < MAX_DIMS; d++) begin
        deg = POLY_DEGREE[d + 1];
        for (int b = 1; b <= MAX_BITS; b++) begin
          if (b <= deg) begin
            val = 32'(SEED_VALUES[(b - 1) * SEED_STRIDE + d + 1]) << (MAX_BITS - b);
          end else begin
            poly = POLY_COEFFS[d + 1];
            val = dir_num[d][b - deg - 1];
            val = val ^ (val >> deg);
            for (int l = deg - 1; l >= 1; l--) begin
              if (poly[0]) val = val ^ dir_num[d][b - l - 1];
              poly = poly >> 1;
            end
          end
          dir_num[d][b - 1] = val[COORD_W-1:0];
        end
      end
    endfunction

    function void set_dimensions(logic [CFG_W-1:0] v);
      dims_reg = v;
    endfunction

    function int pending();
      return expected_coords.size();
    endfunction

    // Gray-code step for one accepted request
    function void take_request(logic req);
      int n;
      int pos;
      coord_result_t r;
      if (!req) return;
      n = (dims_reg == 0) ? 1 : (dims_reg > MAX_DIMS) ? MAX_DIMS : int'(dims_reg);
      pos = -1;
      for (int b = 0; b < MAX_BITS && pos < 0; b++)
        if (!point_count[b]) pos = b;
      if (pos >= 0) begin
        for (int k = 0; k < n; k++) coords[k] = coords[k] ^ dir_num[k][pos];
        point_count = point_count + 1'b1;
      end
      for (int k = 0; k < n; k++) begin
        r.dim_idx = k[DIM_IDX_W-1:0];
        r.coord = coords[k];
        r.last = (k == n - 1);
        r.exhausted = (pos < 0);
        expected_coords.push_back(r);
      end
    endfunction

    function void check_coordinate(coord_result_t got);
      coord_result_t want;
      if (expected_coords.size() == 0) begin
        $error("unexpected coordinate: dim_idx %0d coord %0h", got.dim_idx, got.coord);
        errors++;
        return;
      end
      want = expected_coords.pop_front();
      if (got.dim_idx !== want.dim_idx) begin
        $error("dimension_index expected %0d got %0d", want.dim_idx, got.dim_idx);
        errors++;
      end
      if (got.coord !== want.coord) begin
        $error("coordinate expected %0h got %0h", want.coord, got.coord);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last expected %0d got %0d", want.last, got.last);
        errors++;
      end
      if (got.exhausted !== want.exhausted) begin
        $error("exhausted expected %0d got %0d", want.exhausted, got.exhausted);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_W-1:0]     cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_request;
  logic                 out_valid;
  logic                 out_stall;
  logic [DIM_IDX_W-1:0] out_dimension_index;
  logic [COORD_W-1:0]   out_coordinate;
  logic                 out_last;
  logic                 out_exhausted;

  sobol_point_checker checker_h;
  int src_idle_pct;
  int sink_stall_pct;
  int cycle_count = 0;

  sobol_sequence_generator #(
    .MAX_BITS(MAX_BITS),
    .MAX_DIMS(MAX_DIMS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_request          (in_request),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_dimension_index (out_dimension_index),
    .out_coordinate      (out_coordinate),
    .out_last            (out_last),
    .out_exhausted       (out_exhausted)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sobol_sequence_generator: mismatch");
      $finish;
    end
  end

  // Accepted requests feed the tracker
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) checker_h.take_request(in_request);
  end

  // Accepted coordinates are checked in order
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      checker_h.check_coordinate('{out_dimension_index, out_coordinate, out_last,
                                   out_exhausted});
  end

  // Receiver backpressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // Entered and left at a falling edge; valid stays up for a following request
  task automatic send_request(input logic req);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_request <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain every owed coordinate, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (checker_h.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_dimensions(input logic [CFG_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    checker_h.set_dimensions(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Random points in chunks, each chunk at a fresh dimension setting
  task automatic random_phase(input int idle_pct, input int stall_pct, input int points);
    int sent;
    src_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    sent = 0;
    while (sent < points) begin
      write_dimensions(CFG_W'($urandom_range(7)));
      for (int i = 0; i < 14 && sent < points; i++) begin
        // occasional no-op request
        if ($urandom_range(99) < 10) send_request(1'b0);
        send_request(1'b1);
        sent++;
      end
      drain();
    end
  endtask

  initial begin
    checker_h = new();
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_request = 1'b0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset dimension setting, no-op requests, zero and out-of-range dimensions
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b1);
    drain();
    write_dimensions(3'd0);
    send_request(1'b1);
    send_request(1'b1);
    drain();
    write_dimensions(3'd6);
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b1);
    drain();
    write_dimensions(3'd7);
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b1);
    drain();
    write_dimensions(3'd1);
    send_request(1'b1);
    send_request(1'b1);
    drain();
    write_dimensions(3'd4);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    drain();

    random_phase(0, 0, 60);
    random_phase(57, 0, 60);
    random_phase(0, 57, 60);
    random_phase(20, 20, 60);

    if (checker_h.errors == 0 && checker_h.pending() == 0) begin
      $display("sobol_sequence_generator: match");
    end else begin
      $display("sobol_sequence_generator: mismatch");
    end
    $finish;
  end

endmodule

### sobol_sequence_generator.f
+incdir+design
design/sobol_pkg.sv
design/sobol_ram.sv
design/sobol_sequence_generator.sv
verif/sobol_sequence_generator_tb.sv
